// ===== rtl/scan_polar_to_world_points_assert.svh =====
// assertion macros for the scan point former
`ifndef SCAN_POLAR_TO_WORLD_POINTS_ASSERT_SVH
`define SCAN_POLAR_TO_WORLD_POINTS_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SPW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spw check failed");
// next-cycle implication
`define SPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spw check failed");
`endif

// ===== rtl/spw_pkg.sv =====
// ----------------------------------------------------------------------------
// spw_pkg
// constants and tables shared by the scan point former
// ----------------------------------------------------------------------------
`default_nettype none
package spw_pkg;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int RANGE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 24;
    localparam int OFFSET_BITS    = 16;
    localparam int ROUNDS         = 24;
    localparam int ROUND_BITS     = 5;
    // datapath width: up to 2^25 magnitudes scaled by 2^30, plus growth
    localparam int DP_BITS        = 60;
    localparam int MUL_BITS       = 31;
    localparam logic [MUL_BITS-1:0] INVK_Q30 = 31'd652032874;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_START_ANGLE  = 3'd0,
        REG_ANGLE_STEP   = 3'd1,
        REG_MOUNT_X      = 3'd2,
        REG_MOUNT_Y      = 3'd3,
        REG_ROBOT_X      = 3'd4,
        REG_ROBOT_Y      = 3'd5,
        REG_ROBOT_HEAD   = 3'd6
    } cfg_reg_t;

    // arctangent of 2^-i in 2^32 turns
    function automatic logic [31:0] atan_turn(input logic [ROUND_BITS-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/scan_polar_to_world_points.sv =====
// ----------------------------------------------------------------------------
// scan_polar_to_world_points
// lidar range samples to sensor-frame and world-frame points
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready) takes one range item; out channel
//   (out_valid/out_ready) gives one point item per input item.
//   config: cfg_we/cfg_idx/cfg_data, written while idle.
//   each valid item runs two rotations on one shared cordic unit; a
//   rotation steps through start, a bit-serial gain multiply, a load
//   step plus 24 rounds, and an output step. a valid item runs the sensor
//   rotation, the world start state and the world rotation before the hold
//   state raises out_valid; an invalid range goes straight to the hold state.
//   one item is in flight at a time; the next item can be accepted at the
//   edge where the result leaves.
//   the result sits in the output registers, which also hold the work in
//   progress, so in_ready stays low while the receiver stalls.
//   reset clears the beam angle and loads the default registers.
// ----------------------------------------------------------------------------
`default_nettype none
module scan_polar_to_world_points
    import spw_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int RANGE_BITS = RANGE_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [RANGE_BITS-1:0]         range_mm,
    input  wire logic                          range_ok,
    input  wire logic                          scan_start,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [RANGE_BITS:0]         sensor_x,
    output logic signed [RANGE_BITS:0]         sensor_y,
    output logic signed [COORD_BITS-1:0]       world_x,
    output logic signed [COORD_BITS-1:0]       world_y,
    output logic                               point_ok
);
`include "scan_polar_to_world_points_assert.svh"
    localparam int RB = COORD_BITS + 2;
    typedef enum logic [2:0] {S_IDLE, S_SENS, S_WSTART, S_WORLD, S_HOLD} state_t;

    logic [ANGLE_BITS-1:0]          start_angle_reg, angle_step_reg, heading_reg, beam_reg;
    logic signed [OFFSET_BITS-1:0]  mx_reg, my_reg;
    logic signed [COORD_BITS-2:0]   rx_reg, ry_reg;
    state_t                         state_reg;
    logic                           ok_reg;
    logic signed [RANGE_BITS:0]     sx_reg, sy_reg;
    logic signed [COORD_BITS-1:0]   wx_reg, wy_reg;
    logic                           rot_start;
    logic                           rot_done;
    logic signed [RB-1:0]           rin_x, rin_y;
    logic [ANGLE_BITS-1:0]          rang;
    logic signed [RB+1:0]           rout_x, rout_y;
    logic signed [RB+1:0]           wsx, wsy;

    localparam logic signed [RB+1:0] SHI = (RB+2)'((1 <<< RANGE_BITS) - 1);
    localparam logic signed [RB+1:0] SLO = -(RB+2)'(1 <<< RANGE_BITS);
    localparam logic signed [RB+1:0] WHI = (RB+2)'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [RB+1:0] WLO = -(RB+2)'(64'sd1 <<< (COORD_BITS-1));

    // rotation operands by phase
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rin_x = RB'($signed({1'b0, range_mm}));
            rin_y = '0;
            rang  = scan_start ? start_angle_reg : beam_reg;
        end
        else
        begin
            rin_x = RB'(sx_reg) + RB'(mx_reg);
            rin_y = RB'(sy_reg) + RB'(my_reg);
            rang  = heading_reg;
        end
        wsx = rout_x + (RB+2)'(rx_reg);
        wsy = rout_y + (RB+2)'(ry_reg);
    end

    assign rot_start = (state_reg == S_IDLE && in_valid && in_ready && range_ok)
                    || (state_reg == S_WSTART);

    spw_rotator #(.ANGLE_BITS(ANGLE_BITS), .IN_BITS(RB)) u_rot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start),
        .in_x  (rin_x),
        .in_y  (rin_y),
        .angle (rang),
        .done  (rot_done),
        .out_x (rout_x),
        .out_y (rout_y)
    );

    assign in_ready = (state_reg == S_IDLE) && !(out_valid && !out_ready);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            mx_reg          <= -16'sd87;
            my_reg          <= 16'sd13;
            rx_reg          <= '0;
            ry_reg          <= '0;
            heading_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_START_ANGLE: start_angle_reg <= cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_data[ANGLE_BITS-1:0];
                REG_MOUNT_X:     mx_reg          <= cfg_data[OFFSET_BITS-1:0];
                REG_MOUNT_Y:     my_reg          <= cfg_data[OFFSET_BITS-1:0];
                REG_ROBOT_X:     rx_reg          <= cfg_data[COORD_BITS-2:0];
                REG_ROBOT_Y:     ry_reg          <= cfg_data[COORD_BITS-2:0];
                REG_ROBOT_HEAD:  heading_reg     <= cfg_data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // item sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            beam_reg  <= '0;
            out_valid <= 1'b0;
            ok_reg    <= 1'b0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            wx_reg    <= '0;
            wy_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_HOLD && (!out_valid || out_ready))
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        beam_reg <= rang + angle_step_reg;
                        ok_reg   <= range_ok;
                        sx_reg   <= '0;
                        sy_reg   <= '0;
                        wx_reg   <= '0;
                        wy_reg   <= '0;
                        state_reg <= range_ok ? S_SENS : S_HOLD;
                    end
                end
                S_SENS:
                begin
                    if (rot_done)
                    begin
                        sx_reg <= (rout_x > SHI) ? (RANGE_BITS+1)'(SHI) :
                                  (rout_x < SLO) ? (RANGE_BITS+1)'(SLO) :
                                  (RANGE_BITS+1)'(rout_x);
                        sy_reg <= (rout_y > SHI) ? (RANGE_BITS+1)'(SHI) :
                                  (rout_y < SLO) ? (RANGE_BITS+1)'(SLO) :
                                  (RANGE_BITS+1)'(rout_y);
                        state_reg <= S_WSTART;
                    end
                end
                S_WSTART:
                begin
                    // world rotation starts from the registered sensor point
                    state_reg <= S_WORLD;
                end
                S_WORLD:
                begin
                    if (rot_done)
                    begin
                        wx_reg <= (wsx > WHI) ? COORD_BITS'(WHI) :
                                  (wsx < WLO) ? COORD_BITS'(WLO) : COORD_BITS'(wsx);
                        wy_reg <= (wsy > WHI) ? COORD_BITS'(WHI) :
                                  (wsy < WLO) ? COORD_BITS'(WLO) : COORD_BITS'(wsy);
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (!out_valid || out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sensor_x = sx_reg;
    assign sensor_y = sy_reg;
    assign world_x  = wx_reg;
    assign world_y  = wy_reg;
    assign point_ok = ok_reg;

    `SPW_ASSERT_IMP(a_busy_no_accept, state_reg != S_IDLE, !in_ready)
    `SPW_ASSERT_IMP(a_bad_zero, out_valid && !point_ok,
        sensor_x == '0 && world_x == '0 && world_y == '0)
    `SPW_ASSERT_NEXT(a_hold_to_out, state_reg == S_HOLD && !out_valid, out_valid)
endmodule
`default_nettype wire

// ===== rtl/spw_rotator.sv =====
// ----------------------------------------------------------------------------
// spw_rotator
// gain-corrected cordic rotation of an integer vector, one round per cycle,
// the gain multiply done bit-serially over the multiplier bits
// ----------------------------------------------------------------------------
`default_nettype none
module spw_rotator
    import spw_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int IN_BITS    = 26
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [IN_BITS-1:0]   in_x,
    input  wire logic signed [IN_BITS-1:0]   in_y,
    input  wire logic [ANGLE_BITS-1:0]       angle,
    output logic                             done,
    output logic signed [IN_BITS+1:0]        out_x,
    output logic signed [IN_BITS+1:0]        out_y
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROT, S_OUT} state_t;
    localparam int MB = $clog2(MUL_BITS + 1);

    state_t                     state_reg;
    logic [MB-1:0]              mcnt_reg;
    logic [ROUND_BITS-1:0]      rcnt_reg;
    logic signed [DP_BITS-1:0]  x_reg, y_reg, ax_reg, ay_reg;
    logic signed [32:0]         z_reg;
    logic [MUL_BITS-1:0]        k_reg;

    logic signed [DP_BITS-1:0]  dx, dy, rx, ry;
    logic signed [32:0]         z0, at;
    logic                       wrap;

    // angle widened to a signed turn fraction
    always_comb
    begin
        z0   = {{1{angle[ANGLE_BITS-1]}}, angle, {(32-ANGLE_BITS){1'b0}}};
        wrap = (z0 > 33'sh040000000) || (z0 < -33'sh040000000);
        dx   = y_reg >>> rcnt_reg;
        dy   = x_reg >>> rcnt_reg;
        at   = {1'b0, atan_turn(rcnt_reg)};
        rx   = ax_reg + (DP_BITS'(1) <<< 29);
        ry   = ay_reg + (DP_BITS'(1) <<< 29);
    end

    assign out_x = (IN_BITS+2)'(rx >>> 30);
    assign out_y = (IN_BITS+2)'(ry >>> 30);

    // sequencer: shift-add gain multiply, then cordic rounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
            mcnt_reg  <= '0;
            rcnt_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            ax_reg    <= '0;
            ay_reg    <= '0;
            z_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        // past a quarter turn: negate and fold by half a turn
                        x_reg    <= wrap ? -DP_BITS'(in_x) : DP_BITS'(in_x);
                        y_reg    <= wrap ? -DP_BITS'(in_y) : DP_BITS'(in_y);
                        ax_reg   <= '0;
                        ay_reg   <= '0;
                        k_reg    <= INVK_Q30;
                        mcnt_reg <= '0;
                        z_reg    <= wrap ? (z0[32] ? z0 + 33'sh080000000
                                                   : z0 - 33'sh080000000) : z0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // one multiplier bit per cycle
                    if (k_reg[0])
                    begin
                        ax_reg <= ax_reg + x_reg;
                        ay_reg <= ay_reg + y_reg;
                    end
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                    k_reg <= k_reg >> 1;
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == MB'(MUL_BITS - 1))
                    begin
                        state_reg <= S_ROT;
                        rcnt_reg  <= '0;
                    end
                end
                S_ROT:
                begin
                    // on entry x_reg/y_reg are unused, swap in the products
                    if (rcnt_reg == '0 && mcnt_reg == MB'(MUL_BITS))
                    begin
                        x_reg    <= ax_reg;
                        y_reg    <= ay_reg;
                        mcnt_reg <= '0;
                    end
                    else
                    begin
                        if (!z_reg[32])
                        begin
                            x_reg <= x_reg - dx;
                            y_reg <= y_reg + dy;
                            z_reg <= z_reg - at;
                        end
                        else
                        begin
                            x_reg <= x_reg + dx;
                            y_reg <= y_reg - dy;
                            z_reg <= z_reg + at;
                        end
                        rcnt_reg <= rcnt_reg + 1'b1;
                        if (rcnt_reg == ROUND_BITS'(ROUNDS - 1))
                            state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    ax_reg    <= x_reg;
                    ay_reg    <= y_reg;
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_scan_polar_to_world_points.sv =====
// ----------------------------------------------------------------------------
// tb_scan_polar_to_world_points
// random and directed check of the scan point former against a local
// cordic predictor; both channels idle at random, registers change between
// phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// one predicted point item
typedef struct {
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [23:0] wx;
    logic signed [23:0] wy;
    logic               ok;
} point_t;

// ordered store of predicted points, checked against the output channel
class point_board;
    point_t pending[$];
    int     errors;

    function new();
        errors = 0;
    endfunction

    function void note_input(point_t p);
        pending = {pending, p};
    endfunction

    function void check_point(logic signed [16:0] sx, logic signed [16:0] sy,
                              logic signed [23:0] wx, logic signed [23:0] wy,
                              logic ok);
        point_t e;
        if (pending.size() == 0)
        begin
            $error("point item with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (sx !== e.sx)
        begin
            $error("sensor_x expected %0d actual %0d", e.sx, sx);
            errors++;
        end
        if (sy !== e.sy)
        begin
            $error("sensor_y expected %0d actual %0d", e.sy, sy);
            errors++;
        end
        if (wx !== e.wx)
        begin
            $error("world_x expected %0d actual %0d", e.wx, wx);
            errors++;
        end
        if (wy !== e.wy)
        begin
            $error("world_y expected %0d actual %0d", e.wy, wy);
            errors++;
        end
        if (ok !== e.ok)
        begin
            $error("point_ok expected %0d actual %0d", e.ok, ok);
            errors++;
        end
    endfunction
endclass

module tb_scan_polar_to_world_points;
    import spw_pkg::*;

    localparam longint INVK = 64'sd652032874;
    localparam longint LIMIT_CYCLES = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] range_mm;
    logic        range_ok;
    logic        scan_start;
    logic        out_valid;
    logic        out_ready;
    logic signed [16:0] sensor_x;
    logic signed [16:0] sensor_y;
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic        point_ok;

    // predictor copy of the registers and beam angle
    logic [15:0] first_angle;
    logic [15:0] beam_step;
    logic signed [15:0] mount_x;
    logic signed [15:0] mount_y;
    logic signed [22:0] pose_x;
    logic signed [22:0] pose_y;
    logic [15:0] pose_head;
    logic [15:0] next_angle;

    point_board board;
    longint     cycles;
    bit         hold_out;
    bit         wild_hold;

    scan_polar_to_world_points DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .range_mm(range_mm), .range_ok(range_ok), .scan_start(scan_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .sensor_x(sensor_x), .sensor_y(sensor_y),
        .world_x(world_x), .world_y(world_y), .point_ok(point_ok)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint arctan_of(int i);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        return t[i];
    endfunction

    // cordic rotation of an integer vector by a 16-bit binary angle
    task automatic rotate_vec(inout longint vx, inout longint vy, input logic [15:0] ang);
        longint z, x, y, dx, dy;
        z = longint'({ang, 16'h0});
        if (z >= 64'sh80000000) z -= 64'sh100000000;
        x = vx * INVK;
        y = vy * INVK;
        if (z > 64'sh40000000)
        begin
            z -= 64'sh80000000;
            x = -x;
            y = -y;
        end
        else if (z < -64'sh40000000)
        begin
            z += 64'sh80000000;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_of(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_of(i);
            end
        end
        vx = (x + (64'sd1 <<< 29)) >>> 30;
        vy = (y + (64'sd1 <<< 29)) >>> 30;
    endtask

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // expected point for one accepted range item, advances the beam angle
    task automatic predict_point(logic [15:0] r, logic ok, logic st);
        point_t p;
        logic [15:0] ang;
        longint sx, sy, wx, wy;
        ang = st ? first_angle : next_angle;
        next_angle = ang + beam_step;
        sx = 0; sy = 0; wx = 0; wy = 0;
        if (ok)
        begin
            sx = longint'(r);
            rotate_vec(sx, sy, ang);
            sx = clamp(sx, 17);
            sy = clamp(sy, 17);
            wx = sx + mount_x;
            wy = sy + mount_y;
            rotate_vec(wx, wy, pose_head);
            wx = clamp(wx + pose_x, 24);
            wy = clamp(wy + pose_y, 24);
        end
        p.sx = sx[16:0];
        p.sy = sy[16:0];
        p.wx = wx[23:0];
        p.wy = wy[23:0];
        p.ok = ok;
        board.note_input(p);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_START_ANGLE: first_angle = val[15:0];
            REG_ANGLE_STEP:  beam_step   = val[15:0];
            REG_MOUNT_X:     mount_x     = val[15:0];
            REG_MOUNT_Y:     mount_y     = val[15:0];
            REG_ROBOT_X:     pose_x      = val[22:0];
            REG_ROBOT_Y:     pose_y      = val[22:0];
            REG_ROBOT_HEAD:  pose_head   = val[15:0];
            default: ;
        endcase
    endtask

    // offer one range item, hold it until accepted; valid drops only for a gap
    task automatic send_range(logic [15:0] r, logic ok, logic st, bit idle_gap);
        int gap;
        gap = idle_gap ? $urandom_range(0, 12) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        range_mm   <= r;
        range_ok   <= ok;
        scan_start <= st;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_point(r, ok, st);
    endtask

    // wait until every point is back and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic random_regs(bit extreme);
        if (extreme)
        begin
            write_reg(REG_START_ANGLE, 32'h8000);
            write_reg(REG_ANGLE_STEP, 32'h7fff);
            write_reg(REG_MOUNT_X, 32'h7fff);
            write_reg(REG_MOUNT_Y, 32'h8000);
            write_reg(REG_ROBOT_X, 32'h3fffff);
            write_reg(REG_ROBOT_Y, 32'h400000);
            write_reg(REG_ROBOT_HEAD, 32'hffff);
        end
        else
        begin
            write_reg(REG_START_ANGLE, $urandom);
            write_reg(REG_ANGLE_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 700));
            write_reg(REG_MOUNT_X, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400) - 200);
            write_reg(REG_MOUNT_Y, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400) - 200);
            write_reg(REG_ROBOT_X, $urandom);
            write_reg(REG_ROBOT_Y, $urandom);
            write_reg(REG_ROBOT_HEAD, $urandom);
        end
    endtask

    // output side: random stalls, one long hold when asked
    initial
    begin
        int wait_cycles;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (2000) @(posedge clk);
                hold_out = 1'b0;
            end
            wait_cycles = wild_hold ? $urandom_range(0, 12) : 0;
            if (wait_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            board.check_point(sensor_x, sensor_y, world_x, world_y, point_ok);
        end
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] r;
        board      = new();
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        range_mm   = '0;
        range_ok   = 1'b0;
        scan_start = 1'b0;
        hold_out   = 1'b0;
        wild_hold  = 1'b1;
        first_angle = 16'd0;
        beam_step   = 16'd0;
        mount_x     = -16'sd87;
        mount_y     = 16'sd13;
        pose_x      = '0;
        pose_y      = '0;
        pose_head   = 16'd0;
        next_angle  = 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, no scan start yet: angle counts from zero
        send_range(16'd1000, 1'b1, 1'b0, 1'b0);
        send_range(16'hffff, 1'b1, 1'b0, 1'b0);
        send_range(16'd0, 1'b1, 1'b0, 1'b1);
        send_range(16'hffff, 1'b0, 1'b0, 1'b1);
        drain();

        // quarter-turn steps hit the fold at plus and minus a quarter turn
        write_reg(REG_START_ANGLE, 32'h4000);
        write_reg(REG_ANGLE_STEP, 32'h4000);
        send_range(16'hffff, 1'b1, 1'b1, 1'b0);
        repeat (4) send_range(16'hffff, 1'b1, 1'b0, 1'b0);
        send_range(16'd5, 1'b0, 1'b0, 1'b0);
        send_range(16'd12345, 1'b1, 1'b1, 1'b1);
        drain();

        // extremes of every register, world saturation
        random_regs(1'b1);
        send_range(16'hffff, 1'b1, 1'b1, 1'b0);
        repeat (4) send_range(16'hffff, 1'b1, 1'b0, 1'b1);
        send_range(16'h0001, 1'b1, 1'b0, 1'b1);
        send_range(16'h8000, 1'b0, 1'b1, 1'b1);
        drain();
        write_reg(REG_ROBOT_X, 32'h400000);
        write_reg(REG_ROBOT_Y, 32'h3fffff);
        write_reg(REG_ROBOT_HEAD, 32'h8000);
        write_reg(REG_MOUNT_X, 32'h8000);
        write_reg(REG_MOUNT_Y, 32'h7fff);
        send_range(16'hffff, 1'b1, 1'b1, 1'b0);
        send_range(16'h7fff, 1'b1, 1'b0, 1'b0);
        drain();

        // long receiver hold while input keeps coming
        hold_out = 1'b1;
        repeat (6) send_range(16'($urandom), 1'b1, 1'b0, 1'b0);
        drain();

        // random phases: scans of random content under changing poses
        for (int ph = 0; ph < 24; ph++)
        begin
            random_regs(1'b0);
            wild_hold = (ph % 5 != 4);
            for (int n = 0; n < 58; n++)
            begin
                r = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 20000));
                send_range(r, $urandom_range(0, 9) != 0,
                           (n == 0) || ($urandom_range(0, 29) == 0),
                           wild_hold && (ph % 3 != 2));
            end
            drain();
        end

        wild_hold = 1'b1;
        drain();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
